[hdl/pulse_period_tachometer_defines.svh]
// Assertion macros for the pulse period tachometer checker.
// Depends on nothing; included by the checker file only.
`ifndef PULSE_PERIOD_TACHOMETER_DEFINES_SVH
`define PULSE_PERIOD_TACHOMETER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tachometer check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define PPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tachometer check failed in the following cycle");

`endif

[hdl/ppt_pkg.sv]
// Shared types and constants of the pulse period tachometer.
// Used by the controller, the datapath and the top level; depends on nothing.
package ppt_pkg;

    localparam int TIME_W = 32;
    localparam int RPM_W  = 26;

    // Numerator of the speed division: microseconds in one minute.
    localparam logic [RPM_W-1:0]  RPM_NUMERATOR = 26'd60000000;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd200000;

    // One quotient bit is produced per divider step.
    localparam int DIV_STEPS = RPM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration port: word-addressed registers.
    localparam int ADDR_W = 3;
    localparam logic REG_TIMEOUT = 1'b0;

    typedef enum logic {
        OP_PULSE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic pulse;     // record a pulse timestamp
        logic query;     // evaluate a query and set up the divider
        logic step;      // one restoring division step
        logic load_out;  // move the finished reading to the output register
    } t_dp_cmd;

endpackage

[hdl/ppt_ctrl.sv]
// Controller of the pulse period tachometer: sequences queries through the divider.
// Depends on ppt_pkg.
module ppt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_query,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output ppt_pkg::t_dp_cmd o_cmd
);
    import ppt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_LOAD
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_in_xfer;
    logic             w_out_free;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in_query) begin
                        o_cmd.query = 1'b1;
                        n_cnt       = '0;
                        n_state     = S_DIV;
                    end else begin
                        o_cmd.pulse = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // Wait until the output register is empty or being emptied.
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, step counter and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hdl/ppt_datapath.sv]
// Datapath of the pulse period tachometer: pulse state, timeout checks,
// radix-2 restoring divider and output register. Depends on ppt_pkg.
module ppt_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ppt_pkg::t_dp_cmd          i_cmd,
    input  logic [ppt_pkg::TIME_W-1:0] i_time_us,
    input  logic                      i_cfg_we,
    input  logic [ppt_pkg::TIME_W-1:0] i_cfg_wdata,
    output logic [ppt_pkg::TIME_W-1:0] o_timeout_us,
    output logic [ppt_pkg::TIME_W-1:0] o_interval_us,
    output logic [ppt_pkg::RPM_W-1:0]  o_speed_rpm,
    output logic                      o_reading_valid
);
    import ppt_pkg::*;

    logic [TIME_W-1:0] r_timeout;
    logic [TIME_W-1:0] r_last_pulse;
    logic [TIME_W-1:0] r_held;
    logic              r_have_pulse;
    logic              r_have_int;

    logic [TIME_W-1:0] r_div;
    logic              r_nonzero;
    logic [TIME_W-1:0] r_rem;
    logic [RPM_W-1:0]  r_quot;

    logic [TIME_W-1:0] r_out_interval;
    logic [RPM_W-1:0]  r_out_rpm;
    logic              r_out_flag;

    logic [TIME_W-1:0] w_delta;
    logic              w_fresh;
    logic [TIME_W-1:0] w_reported;
    logic [TIME_W:0]   w_trial;
    logic              w_fits;
    logic [TIME_W-1:0] n_rem;
    logic [RPM_W-1:0]  n_quot;

    // Gap or age since the last pulse, modulo 2^32, against the timeout.
    assign w_delta    = i_time_us - r_last_pulse;
    assign w_fresh    = (w_delta < r_timeout);
    assign w_reported = (r_have_int && w_fresh) ? r_held : '0;

    // One restoring division step: bring down the next numerator bit.
    always_comb begin
        w_trial = {r_rem, r_quot[RPM_W-1]};
        w_fits  = (w_trial >= {1'b0, r_div});
        if (w_fits) begin
            n_rem = TIME_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[TIME_W-1:0];
        end
        n_quot = {r_quot[RPM_W-2:0], w_fits};
    end

    // Configuration and pulse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= TIMEOUT_RESET;
            r_last_pulse <= '0;
            r_held       <= '0;
            r_have_pulse <= 1'b0;
            r_have_int   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.pulse) begin
                if (r_have_pulse && w_fresh) begin
                    r_held     <= w_delta;
                    r_have_int <= 1'b1;
                end
                r_last_pulse <= i_time_us;
                r_have_pulse <= 1'b1;
            end else if (i_cmd.query && r_have_int && !w_fresh) begin
                r_have_int <= 1'b0;
            end
        end
    end

    // Divider registers: the quotient register starts with the numerator and
    // fills with quotient bits from the bottom as numerator bits leave the top.
    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_div     <= w_reported;
            r_nonzero <= (w_reported != '0);
            r_rem     <= '0;
            r_quot    <= RPM_NUMERATOR;
        end else if (i_cmd.step) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    // Output register; a zero interval reports zero speed and not valid.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_interval <= r_div;
            r_out_rpm      <= r_nonzero ? r_quot : '0;
            r_out_flag     <= r_nonzero;
        end
    end

    assign o_timeout_us    = r_timeout;
    assign o_interval_us   = r_out_interval;
    assign o_speed_rpm     = r_out_rpm;
    assign o_reading_valid = r_out_flag;

endmodule

[hdl/pulse_period_tachometer.sv]
// Pulse period tachometer. A pulse item (tuser 0) is accepted back to back.
// A query item (tuser 1) holds the input while it checks the pulse age, runs
// 26 steps of the radix-2 restoring divider that forms 60000000 / interval
// one quotient bit per cycle, and loads the output register; the load waits
// while an earlier reading is still held at the output, which stretches the
// query by the length of that stall. The input is then ready again, and
// pulses are taken while a reading still waits at the output. A pulse gap at
// or beyond timeout_us (byte address 0, reset 200000) is not taken as an
// interval and leaves the held one as it was; a query whose last pulse is
// that old clears the interval. An invalid or zero interval reads as 0, 0
// with tuser low.
// Depends on ppt_pkg, ppt_ctrl and ppt_datapath.
module pulse_period_tachometer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input stream.
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,  // [31:0] time_us
    input  logic [0:0]                  i_s_axis_tuser,  // [0] opcode
    // Output stream.
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [63:0]                 o_m_axis_tdata,  // [31:0] interval_us, [57:32] speed_rpm
    output logic [0:0]                  o_m_axis_tuser,  // [0] reading_valid
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppt_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ppt_pkg::*;

    t_dp_cmd           w_cmd;
    logic              w_cfg_we;
    logic [TIME_W-1:0] w_timeout;
    logic [TIME_W-1:0] w_interval;
    logic [RPM_W-1:0]  w_rpm;
    logic              w_flag;

    // Register access: one word register, decoded on the word address.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);
    assign prdata   = (paddr[2] == REG_TIMEOUT) ? w_timeout : '0;

    ppt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_query  (i_s_axis_tuser[0] == OP_QUERY),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    ppt_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_time_us       (i_s_axis_tdata),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_wdata     (pwdata),
        .o_timeout_us    (w_timeout),
        .o_interval_us   (w_interval),
        .o_speed_rpm     (w_rpm),
        .o_reading_valid (w_flag)
    );

    // Pack the reading; the top bits of the data word are padding.
    assign o_m_axis_tdata = {6'b0, w_rpm, w_interval};
    assign o_m_axis_tuser = w_flag;

endmodule

[hdl/pulse_period_tachometer_checker.sv]
// Port-level checks of the pulse period tachometer, bound to the top level.
// Depends on pulse_period_tachometer_defines.svh.
`include "pulse_period_tachometer_defines.svh"

module pulse_period_tachometer_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    // A stalled reading keeps its value.
    `PPT_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // A valid reading has a nonzero interval and a speed within range.
    `PPT_ASSERT_NOW(a_valid_reading, o_m_axis_tvalid && o_m_axis_tuser[0], (o_m_axis_tdata[31:0] != 32'd0) && (o_m_axis_tdata[57:32] <= 26'd60000000))

    // An invalid reading is all zeros.
    `PPT_ASSERT_NOW(a_invalid_zero, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata == 64'd0)

    // A query transfer occupies the divider, so the input is busy afterwards.
    `PPT_ASSERT_NEXT(a_query_busy, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0], !o_s_axis_tready)

endmodule

bind pulse_period_tachometer pulse_period_tachometer_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
